### sv/integer_matrix_determinant_unit_assert.svh
// ----------------------------------------------------------------------------
// Determinant unit assertion macros
// Short forms for the concurrent checks on the unit's ports, clocked on clk
// and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_DETERMINANT_UNIT_ASSERT_SVH
`define INTEGER_MATRIX_DETERMINANT_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define IMDU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define IMDU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/imdu_pkg.sv
// ----------------------------------------------------------------------------
// imdu_pkg
// Shared constants and the controller-to-datapath command bundle of the
// integer matrix determinant unit.
// ----------------------------------------------------------------------------
package imdu_pkg;

	// Default build sizes
	localparam int MAX_ORDER_DEF  = 4;
	localparam int ELEM_WIDTH_DEF = 16;

	// Order register
	localparam int                     ORDER_WIDTH = 3;
	localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 3'd4;

	// Result width and the operand slice of the shared multiplier
	localparam int DET_WIDTH = 64;
	localparam int MUL_WIDTH = 32;

	// One strobe per datapath action
	typedef struct packed {
		logic elem_wr;     // write the accepted element into the matrix store
		logic run_start;   // last element taken: clear the overflow flag
		logic mask_start;  // new column subset: clear the accumulator
		logic issue;       // read element and minor for the current column
		logic mag;         // take magnitudes and product sign
		logic mul_lo;      // low partial product
		logic mul_hi;      // high partial product
		logic sum;         // combine partials, saturate the term
		logic acc;         // saturating add of the term
		logic minor_wr;    // store the finished minor
		logic out_load;    // move the determinant into the output register
		logic odd;         // current column sits at an odd position
	} dp_cmd_t;

endpackage

### sv/imdu_ctrl.sv
// ----------------------------------------------------------------------------
// imdu_ctrl
// Load counter, order register and the sequencer that walks column subsets
// and their columns for the cofactor expansion.
// ----------------------------------------------------------------------------
module imdu_ctrl #(
	parameter int MAX_ORDER = imdu_pkg::MAX_ORDER_DEF,
	localparam int DEPTH = MAX_ORDER * MAX_ORDER,
	localparam int SAW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int OW = $clog2(MAX_ORDER + 1),
	localparam int JW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [imdu_pkg::ORDER_WIDTH-1:0]   matrix_order,
	input  logic                               in_valid,
	output logic                               in_ready,
	output logic                               out_valid,
	input  logic                               out_ready,
	output imdu_pkg::dp_cmd_t                  cmd,
	output logic [SAW-1:0]                     load_addr,
	output logic [OW-1:0]                      order,
	output logic [MAX_ORDER-1:0]               mask,
	output logic [JW-1:0]                      col
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_LOAD,
		S_MSTART,
		S_SCAN,
		S_MAG,
		S_MLO,
		S_MHI,
		S_SUM,
		S_ACC,
		S_MEND,
		S_DONE
	} state_t;

	state_t                             state_q;
	logic [imdu_pkg::ORDER_WIDTH-1:0]   order_cfg_q;
	logic [CW-1:0]                      cnt_q;
	logic [OW-1:0]                      n_q;
	logic [MAX_ORDER-1:0]               mask_q;
	logic [JW-1:0]                      j_q;
	logic                               odd_q;
	logic                               out_valid_q;

	logic [OW-1:0]                      eff_order;
	logic [2*OW-1:0]                    nn;
	logic [MAX_ORDER-1:0]               full_mask;
	logic                               load_done;
	logic                               j_last;
	logic                               out_free;
	logic                               in_acc;

	// Order in force: zero reads as one, large values clamp
	always_comb begin
		if (order_cfg_q == '0) begin
			eff_order = OW'(1);
		end else if (int'(order_cfg_q) > MAX_ORDER) begin
			eff_order = OW'(MAX_ORDER);
		end else begin
			eff_order = OW'(order_cfg_q);
		end
	end

	assign nn        = (2*OW)'(eff_order) * (2*OW)'(eff_order);
	assign load_done = (int'(cnt_q) + 1 >= int'(nn));
	assign j_last    = (int'(j_q) + 1 == int'(n_q));
	assign out_free  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && (state_q == S_LOAD);

	// All columns of the matrix in use
	always_comb begin
		for (int i = 0; i < MAX_ORDER; i++) begin
			full_mask[i] = (i < int'(n_q));
		end
	end

	// Sequencer state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			order_cfg_q <= imdu_pkg::ORDER_RESET;
			cnt_q       <= '0;
			n_q         <= '0;
			mask_q      <= '0;
			j_q         <= '0;
			odd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				order_cfg_q <= matrix_order;
			end
			// new result item takes precedence over the drain of the old one
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (load_done) begin
							cnt_q   <= '0;
							n_q     <= eff_order;
							mask_q  <= MAX_ORDER'(1);
							state_q <= S_MSTART;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_MSTART: begin
					j_q     <= '0;
					odd_q   <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (mask_q[j_q]) begin
						state_q <= S_MAG;
					end else if (j_last) begin
						state_q <= S_MEND;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_MAG: state_q <= S_MLO;
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= S_SUM;
				S_SUM: state_q <= S_ACC;
				S_ACC: begin
					odd_q <= ~odd_q;
					if (j_last) begin
						state_q <= S_MEND;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_MEND: begin
					if (mask_q == full_mask) begin
						state_q <= S_DONE;
					end else begin
						mask_q  <= mask_q + 1'b1;
						state_q <= S_MSTART;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Datapath commands
	always_comb begin
		cmd            = '0;
		cmd.elem_wr    = in_acc;
		cmd.run_start  = in_acc && load_done;
		cmd.mask_start = (state_q == S_MSTART);
		cmd.issue      = (state_q == S_SCAN) && mask_q[j_q];
		cmd.mag        = (state_q == S_MAG);
		cmd.mul_lo     = (state_q == S_MLO);
		cmd.mul_hi     = (state_q == S_MHI);
		cmd.sum        = (state_q == S_SUM);
		cmd.acc        = (state_q == S_ACC);
		cmd.minor_wr   = (state_q == S_MEND);
		cmd.out_load   = (state_q == S_DONE) && out_free;
		cmd.odd        = odd_q;
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = out_valid_q;
	assign load_addr = cnt_q[SAW-1:0];
	assign order     = n_q;
	assign mask      = mask_q;
	assign col       = j_q;

endmodule

### sv/imdu_datapath.sv
// ----------------------------------------------------------------------------
// imdu_datapath
// Matrix store, minor store, shared 32-bit multiplier and the saturating
// accumulator of the cofactor expansion.
// ----------------------------------------------------------------------------
module imdu_datapath #(
	parameter int MAX_ORDER  = imdu_pkg::MAX_ORDER_DEF,
	parameter int ELEM_WIDTH = imdu_pkg::ELEM_WIDTH_DEF,
	localparam int DEPTH = MAX_ORDER * MAX_ORDER,
	localparam int SAW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int OW = $clog2(MAX_ORDER + 1),
	localparam int JW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
	input  logic                                      clk,
	input  imdu_pkg::dp_cmd_t                         cmd,
	input  logic [SAW-1:0]                            load_addr,
	input  logic signed [ELEM_WIDTH-1:0]              element_value,
	input  logic [OW-1:0]                             order,
	input  logic [MAX_ORDER-1:0]                      mask,
	input  logic [JW-1:0]                             col,
	output logic signed [imdu_pkg::DET_WIDTH-1:0]     det_value,
	output logic                                      overflow_flag
);

	localparam int DW   = imdu_pkg::DET_WIDTH;
	localparam int MW   = imdu_pkg::MUL_WIDTH;
	localparam int PW   = ELEM_WIDTH + MW;
	localparam int FW   = PW + MW;
	localparam int NMIN = 2 ** MAX_ORDER;

	// Stores
	logic [ELEM_WIDTH-1:0]  store_mem [DEPTH];
	logic [DW-1:0]          minor_mem [NMIN];

	logic [ELEM_WIDTH-1:0]  elem_rd_q;
	logic [DW-1:0]          minor_rd_q;
	logic                   empty_q;
	logic [ELEM_WIDTH-1:0]  ua_q;
	logic [DW-1:0]          ub_q;
	logic                   neg_q;
	logic [PW-1:0]          lo_q;
	logic [PW-1:0]          hi_q;
	logic [DW-1:0]          term_q;
	logic [DW-1:0]          acc_q;
	logic                   ovf_q;
	logic [DW-1:0]          det_q;
	logic                   det_ovf_q;

	logic [OW-1:0]          pop;
	logic [OW-1:0]          row;
	logic [2*OW-1:0]        rd_full;
	logic [SAW-1:0]         rd_addr;
	logic [MAX_ORDER-1:0]   sub_mask;
	logic [DW-1:0]          sub_val;
	logic                   sub_neg;
	logic [DW-1:0]          sub_mag;
	logic                   e_neg;
	logic [ELEM_WIDTH-1:0]  e_mag;
	logic [MW-1:0]          mul_b;
	logic [PW-1:0]          prod;
	logic [FW-1:0]          full_prod;
	logic [DW-1:0]          low_prod;
	logic                   mul_over;
	logic [DW-1:0]          lim;
	logic [DW-1:0]          pm;
	logic [DW-1:0]          term_n;
	logic [DW:0]            sum_x;
	logic                   add_ovf;
	logic [DW-1:0]          acc_n;

	// Subset of k columns expands along row order-k
	always_comb begin
		pop = '0;
		for (int i = 0; i < MAX_ORDER; i++) begin
			pop = pop + OW'(mask[i]);
		end
		row     = order - pop;
		rd_full = (2*OW)'(row) * (2*OW)'(order) + (2*OW)'(col);
		rd_addr = rd_full[SAW-1:0];
		sub_mask      = mask;
		sub_mask[col] = 1'b0;
	end

	// Magnitudes; the empty minor counts as one
	always_comb begin
		sub_val = empty_q ? DW'(1) : minor_rd_q;
		sub_neg = sub_val[DW-1];
		sub_mag = sub_neg ? -sub_val : sub_val;
		e_neg   = elem_rd_q[ELEM_WIDTH-1];
		e_mag   = e_neg ? -elem_rd_q : elem_rd_q;
	end

	// Shared multiplier, one 32-bit slice of the minor per cycle
	assign mul_b = cmd.mul_hi ? ub_q[2*MW-1:MW] : ub_q[MW-1:0];
	assign prod  = {{MW{1'b0}}, ua_q} * {{ELEM_WIDTH{1'b0}}, mul_b};

	// Combine partials and clamp the signed term
	always_comb begin
		full_prod = {hi_q, {MW{1'b0}}} + {{MW{1'b0}}, lo_q};
		low_prod  = full_prod[DW-1:0];
		mul_over  = (|full_prod[FW-1:DW]) ||
			(neg_q ? (low_prod[DW-1] && (|low_prod[DW-2:0])) : low_prod[DW-1]);
		lim       = neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		pm        = mul_over ? lim : low_prod;
		term_n    = neg_q ? -pm : pm;
	end

	// Saturating accumulate
	always_comb begin
		sum_x   = {acc_q[DW-1], acc_q} + {term_q[DW-1], term_q};
		add_ovf = (sum_x[DW] != sum_x[DW-1]);
		if (add_ovf) begin
			acc_n = sum_x[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			acc_n = sum_x[DW-1:0];
		end
	end

	// Matrix and minor stores with registered reads
	always_ff @(posedge clk) begin
		if (cmd.elem_wr) begin
			store_mem[load_addr] <= element_value;
		end
		if (cmd.minor_wr) begin
			minor_mem[mask] <= acc_q;
		end
		if (cmd.issue) begin
			elem_rd_q  <= store_mem[rd_addr];
			minor_rd_q <= minor_mem[sub_mask];
			empty_q    <= (sub_mask == '0);
		end
	end

	// Term pipeline, accumulator and result register
	always_ff @(posedge clk) begin
		if (cmd.mag) begin
			ua_q  <= e_mag;
			ub_q  <= sub_mag;
			neg_q <= e_neg ^ cmd.odd ^ sub_neg;
		end
		if (cmd.mul_lo) begin
			lo_q <= prod;
		end
		if (cmd.mul_hi) begin
			hi_q <= prod;
		end
		if (cmd.sum) begin
			term_q <= term_n;
		end
		if (cmd.run_start) begin
			ovf_q <= 1'b0;
		end else if ((cmd.sum && mul_over) || (cmd.acc && add_ovf)) begin
			ovf_q <= 1'b1;
		end
		if (cmd.mask_start) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_n;
		end
		if (cmd.out_load) begin
			det_q     <= acc_q;
			det_ovf_q <= ovf_q;
		end
	end

	assign det_value     = det_q;
	assign overflow_flag = det_ovf_q;

endmodule

### sv/integer_matrix_determinant_unit.sv
// ----------------------------------------------------------------------------
// integer_matrix_determinant_unit
// Exact determinant of a square signed integer matrix by cofactor expansion.
// ----------------------------------------------------------------------------
// Elements arrive row-major, one per cycle while in_ready is high; the last
// element of an order x order matrix starts the expansion, whose result is
// registered on the output. Every column subset of the bottom rows has its
// minor computed once, lowest subset first, and each term goes in turn through
// magnitudes, low and high partial products on the single shared 32-bit
// multiplier, sum and accumulate. Loading of the next matrix may start while
// the previous result waits on the output. The result is saturated to 64 bits
// and overflow_flag reports any saturation in a product or a sum.
// Write matrix_order only between matrices.
// ----------------------------------------------------------------------------
module integer_matrix_determinant_unit #(
	parameter int MAX_ORDER  = imdu_pkg::MAX_ORDER_DEF,
	parameter int ELEM_WIDTH = imdu_pkg::ELEM_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [imdu_pkg::ORDER_WIDTH-1:0]          matrix_order,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [ELEM_WIDTH-1:0]              element_value,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [imdu_pkg::DET_WIDTH-1:0]     det_value,
	output logic                                      overflow_flag
);

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW    = $clog2(MAX_ORDER + 1);
	localparam int JW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	imdu_pkg::dp_cmd_t      cmd;
	logic [SAW-1:0]         load_addr;
	logic [OW-1:0]          order;
	logic [MAX_ORDER-1:0]   mask;
	logic [JW-1:0]          col;

	// Sequencer
	imdu_ctrl #(
		.MAX_ORDER (MAX_ORDER)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.matrix_order (matrix_order),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.load_addr    (load_addr),
		.order        (order),
		.mask         (mask),
		.col          (col)
	);

	// Stores and arithmetic
	imdu_datapath #(
		.MAX_ORDER  (MAX_ORDER),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.load_addr     (load_addr),
		.element_value (element_value),
		.order         (order),
		.mask          (mask),
		.col           (col),
		.det_value     (det_value),
		.overflow_flag (overflow_flag)
	);

endmodule

### sv/imdu_checker.sv
// ----------------------------------------------------------------------------
// imdu_checker
// Port-level checks of the determinant unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_matrix_determinant_unit_assert.svh"

module imdu_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [imdu_pkg::DET_WIDTH-1:0]        det_value,
	input  logic                                  overflow_flag
);

	// A stalled result holds
	`IMDU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(det_value) && $stable(overflow_flag), "result changed while stalled")

	// A result only appears after the loader was closed for the expansion
	`IMDU_ASSERT_SAME(a_result_after_busy, $rose(out_valid), !$past(in_ready), "result appeared while loading")

	// No result rises in the cycle after an accepted element
	`IMDU_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result right after an element")

	// The loader closes only on an accepted item
	`IMDU_ASSERT_SAME(a_busy_after_item, $fell(in_ready), $past(in_valid), "loader closed without an item")

endmodule

bind integer_matrix_determinant_unit imdu_checker u_imdu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.det_value     (det_value),
	.overflow_flag (overflow_flag)
);

### verif/determinant_checker.sv
// ----------------------------------------------------------------------------
// determinant_checker
// Watches the order, element and result channels of the determinant unit,
// keeps its own copy of the matrix store and the order register, works out
// the saturated cofactor determinant of every completed matrix and compares
// each result item against the oldest one still owed.
// ----------------------------------------------------------------------------
module determinant_checker (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_valid,
	input  logic                                         cfg_ready,
	input  logic [imdu_pkg::ORDER_WIDTH-1:0]             matrix_order,
	input  logic                                         in_valid,
	input  logic                                         in_ready,
	input  logic signed [imdu_pkg::ELEM_WIDTH_DEF-1:0]   element_value,
	input  logic                                         out_valid,
	input  logic                                         out_ready,
	input  logic signed [imdu_pkg::DET_WIDTH-1:0]        det_value,
	input  logic                                         overflow_flag,
	output int                                           mismatch_count,
	output int                                           results_owed
);

	localparam int     MAX_N   = imdu_pkg::MAX_ORDER_DEF;
	localparam int     CELLS   = MAX_N * MAX_N;
	localparam longint DET_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint DET_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [63:0] det;
		logic               ovf;
	} det_result_t;

	// Shadow of the unit's state
	longint                           cells [CELLS];
	int                               load_count = 0;
	logic [imdu_pkg::ORDER_WIDTH-1:0] order_reg  = imdu_pkg::ORDER_RESET;
	det_result_t                      pending_dets [$];
	int                               mismatches = 0;
	bit                               saturated;

	initial begin
		mismatch_count = 0;
		results_owed   = 0;
	end

	function automatic int effective_order(input logic [imdu_pkg::ORDER_WIDTH-1:0] code);
		if (code == 0)
			return 1;
		if (code > MAX_N)
			return MAX_N;
		return code;
	endfunction

	// Clamping add; flags saturation
	function automatic longint add_clamped(input longint a, input longint b);
		longint s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			saturated = 1'b1;
			s = a[63] ? DET_MIN : DET_MAX;
		end
		return s;
	endfunction

	// Clamping multiply on magnitudes, full 128-bit product
	function automatic longint mul_clamped(input longint a, input longint b);
		logic [63:0]  ua, ub, lim;
		logic [127:0] prod;
		logic         neg;
		ua   = a[63] ? 64'd0 - a : a;
		ub   = b[63] ? 64'd0 - b : b;
		neg  = a[63] ^ b[63];
		lim  = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		prod = {64'd0, ua} * {64'd0, ub};
		if (prod > {64'd0, lim}) begin
			saturated = 1'b1;
			prod = {64'd0, lim};
		end
		return neg ? longint'(64'd0 - prod[63:0]) : longint'(prod[63:0]);
	endfunction

	// Cofactor expansion along the top row, built bottom-up: the minor of each
	// column subset over the bottom rows, subsets in increasing numeric order
	function automatic det_result_t cofactor_expand(input int n);
		longint      minor_val [1 << MAX_N];
		longint      acc, e, term;
		int          k, row, pos;
		det_result_t res;
		saturated = 1'b0;
		for (int mask = 1; mask < (1 << n); mask++) begin
			k = 0;
			for (int c = 0; c < n; c++)
				if (mask[c])
					k++;
			row = n - k;
			acc = 0;
			pos = 0;
			for (int c = 0; c < n; c++) begin
				if (mask[c]) begin
					e = cells[row * n + c];
					if (k == 1) begin
						acc = e;
					end else begin
						if (pos % 2 == 1)
							e = -e;
						term = mul_clamped(e, minor_val[mask & ~(1 << c)]);
						acc  = add_clamped(acc, term);
					end
					pos++;
				end
			end
			minor_val[mask] = acc;
		end
		res.det = minor_val[(1 << n) - 1];
		res.ovf = saturated;
		return res;
	endfunction

	// Sample every channel at the clock edge
	always @(posedge clk or negedge arst_n) begin
		det_result_t want;
		int          n;
		if (!arst_n) begin
			load_count = 0;
			order_reg  = imdu_pkg::ORDER_RESET;
			pending_dets.delete();
			results_owed <= 0;
		end else begin
			// result items against the oldest owed determinant
			if (out_valid && out_ready) begin
				if (pending_dets.size() == 0) begin
					$error("result item with none owed: det_value %0d overflow_flag %0b",
						det_value, overflow_flag);
					mismatches++;
				end else begin
					want = pending_dets.pop_front();
					if (det_value !== want.det) begin
						$error("det_value: expected %0d, got %0d", want.det, det_value);
						mismatches++;
					end
					if (overflow_flag !== want.ovf) begin
						$error("overflow_flag: expected %0b, got %0b", want.ovf, overflow_flag);
						mismatches++;
					end
				end
			end

			// element load; a load ends once the count reaches the square of the order in force
			if (in_valid && in_ready) begin
				n = effective_order(order_reg);
				if (load_count < CELLS)
					cells[load_count] = element_value;
				load_count++;
				if (load_count >= n * n) begin
					load_count = 0;
					pending_dets.push_back(cofactor_expand(n));
				end
			end

			// a new order applies from the next cycle on
			if (cfg_valid && cfg_ready)
				order_reg = matrix_order;

			results_owed <= pending_dets.size();
		end
		mismatch_count <= mismatches;
	end

endmodule

### verif/tb_integer_matrix_determinant_unit.sv
// ----------------------------------------------------------------------------
// tb_integer_matrix_determinant_unit
// Drives order writes and matrix elements into the determinant unit with
// random gaps and output stalls: a directed opening (extreme values, an
// overflowing 4x4, order zero, an order cut mid-load) and then random phases
// at every order setting. The checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module tb_integer_matrix_determinant_unit;

	localparam int ELEM_W        = imdu_pkg::ELEM_WIDTH_DEF;
	localparam int OW            = imdu_pkg::ORDER_WIDTH;
	localparam int MAX_N         = imdu_pkg::MAX_ORDER_DEF;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 300;

	localparam logic [OW-1:0]            ORDER_ZERO     = '0;
	localparam logic [OW-1:0]            ORDER_TOP_CODE = '1;
	localparam logic signed [ELEM_W-1:0] ELEM_MAX       = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic signed [ELEM_W-1:0] ELEM_MIN       = {1'b1, {(ELEM_W-1){1'b0}}};

	typedef enum {FILL_ANY, FILL_EXTREME, FILL_SMALL, FILL_MIXED} fill_style_t;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           cfg_valid     = 1'b0;
	logic                           cfg_ready;
	logic [OW-1:0]                  matrix_order  = '0;
	logic                           in_valid      = 1'b0;
	logic                           in_ready;
	logic signed [ELEM_W-1:0]       element_value = '0;
	logic                           out_valid;
	logic                           out_ready     = 1'b0;
	logic signed [imdu_pkg::DET_WIDTH-1:0] det_value;
	logic                           overflow_flag;

	int mismatch_count;
	int results_owed;
	int elements_sent = 0;
	int cycle_count   = 0;
	int ready_hold    = 0;
	bit no_gaps       = 1'b0;

	integer_matrix_determinant_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.matrix_order  (matrix_order),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.det_value     (det_value),
		.overflow_flag (overflow_flag)
	);

	determinant_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.matrix_order   (matrix_order),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.element_value  (element_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.det_value      (det_value),
		.overflow_flag  (overflow_flag),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** integer_matrix_determinant_unit: FAILED **");
			$finish;
		end
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 3);
	endfunction

	// Result side: after each item, hold ready low for a drawn number of cycles
	always @(posedge clk) begin
		int w;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			ready_hold <= 0;
		end else if (out_valid && out_ready) begin
			w = draw_gap();
			ready_hold <= w;
			out_ready  <= (w == 0);
		end else if (!out_ready) begin
			if (ready_hold <= 1)
				out_ready <= 1'b1;
			ready_hold <= (ready_hold > 0) ? ready_hold - 1 : 0;
		end
	end

	function automatic int effective_order(input logic [OW-1:0] code);
		if (code == ORDER_ZERO)
			return 1;
		if (code > MAX_N)
			return MAX_N;
		return code;
	endfunction

	// Orders 3 and 4 dominate; zero and above-range codes turn up too
	function automatic logic [OW-1:0] draw_order();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return imdu_pkg::ORDER_RESET;
			4, 5:       return OW'(3);
			6:          return OW'(2);
			7:          return OW'(1);
			8:          return ORDER_ZERO;
			default:    return OW'($urandom_range(MAX_N + 1, 2 ** OW - 1));
		endcase
	endfunction

	function automatic logic signed [ELEM_W-1:0] pick_element(input fill_style_t style);
		case (style)
			FILL_ANY:     return ELEM_W'($urandom);
			FILL_EXTREME: return $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
			FILL_SMALL:   return ELEM_W'($urandom_range(0, 8) - 4);
			default: begin
				case ($urandom_range(0, 5))
					0:       return ELEM_MIN;
					1:       return ELEM_MAX;
					2:       return '0;
					3:       return ELEM_W'(1);
					4:       return '1;
					default: return ELEM_W'($urandom);
				endcase
			end
		endcase
	endfunction

	// One element item; valid stays high across back-to-back items
	task automatic push_element(input logic signed [ELEM_W-1:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		elements_sent++;
	endtask

	task automatic write_order(input logic [OW-1:0] code);
		cfg_valid    <= 1'b1;
		matrix_order <= code;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and wait for every owed result plus a short margin
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int            random_base;
		int            n;
		int            mats;
		bit            first_phase;
		logic [OW-1:0] code;
		fill_style_t   style;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset order: Hadamard sign pattern at full scale, overflows the sum
		for (int r = 0; r < MAX_N; r++)
			for (int c = 0; c < MAX_N; c++)
				push_element((((r & c) == 1) || ((r & c) == 2)) ? ELEM_MIN : ELEM_MAX);

		// 1x1: the element itself, both extremes
		settle();
		write_order(OW'(1));
		push_element(ELEM_MAX);
		push_element(ELEM_MIN);

		// order zero behaves as 1x1
		settle();
		write_order(ORDER_ZERO);
		push_element('0);
		push_element('1);

		// order cut mid-load: three loaded at 2x2, next item completes at 1x1
		settle();
		write_order(OW'(2));
		repeat (3) push_element(pick_element(FILL_ANY));
		settle();
		write_order(OW'(1));
		push_element(pick_element(FILL_ANY));

		// Random phases, some ending on a partial load
		random_base = elements_sent;
		first_phase = 1'b1;
		while (elements_sent - random_base < RANDOM_ITEMS) begin
			settle();
			code = first_phase ? ORDER_TOP_CODE : draw_order();
			first_phase = 1'b0;
			write_order(code);
			n       = effective_order(code);
			no_gaps = ($urandom_range(0, 4) == 0);
			mats    = $urandom_range(1, 6);
			repeat (mats) begin
				style = fill_style_t'($urandom_range(0, 3));
				repeat (n * n) push_element(pick_element(style));
			end
			if (n > 1 && $urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, n * n - 1)) push_element(pick_element(FILL_ANY));
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** integer_matrix_determinant_unit: PASSED **");
		else
			$display("** integer_matrix_determinant_unit: FAILED **");
		$finish;
	end

endmodule
